// ===== rtl/core/nmea_sentence_check_and_split_macros.svh =====
// ----------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Shorthand for clocked assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECK_AND_SPLIT_MACROS_SVH
`define NMEA_SENTENCE_CHECK_AND_SPLIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NSCS_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("nscs assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define NSCS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("nscs assertion failed");

`endif

// ===== rtl/core/nscs_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Delimiter characters and the hex digit decoder.
// ----------------------------------------------------------------------------
package nscs_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Decimal digits and letters a-f of either case; anything else is not hex.
   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type res;
      res.valid = 1'b0;
      res.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         res.valid = 1'b1;
         res.value = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         res.valid = 1'b1;
         res.value = b[3:0] + 4'd9;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/nmea_sentence_check_and_split.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker and field splitter
// Checks the XOR checksum of each sentence and splits its body into fields.
// ----------------------------------------------------------------------------
//  channel   direction   handshake              payload
//  req       in          req_valid / req_stall  req_data_byte
//  rsp       out         rsp_valid / rsp_stall  char, index, end and verdict flags
//
// Each accepted byte gives exactly one result, shown in the cycle after it is accepted.
// A new byte is taken in every cycle unless req_stall is high; the sentence state and the result
// register are both updated at the edge that accepts it.
// req_stall is high only while a result waits in the output register and
// rsp_stall holds it there. Reset returns to waiting for a dollar.
module nmea_sentence_check_and_split #(
   parameter int BODY_LIMIT      = 128,
   parameter int MAX_FIELDS      = 32,
   parameter int MAX_FIELD_CHARS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_char_valid,
   output logic [7:0] rsp_char_out,
   output logic [4:0] rsp_field_index,
   output logic [3:0] rsp_char_index,
   output logic       rsp_field_end,
   output logic       rsp_sentence_end,
   output logic       rsp_checksum_ok,
   output logic       rsp_field_truncated
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_SUM  = 2'd2;

   localparam logic [7:0] BODY_MAX   = 8'(BODY_LIMIT);
   localparam logic [4:0] LAST_FIELD = 5'(MAX_FIELDS - 1);
   localparam logic [4:0] CHAR_MAX   = 5'(MAX_FIELD_CHARS);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic [7:0] body_count_ff, body_count_in;
   logic [4:0] current_field_ff, current_field_in;
   logic [4:0] current_char_ff, current_char_in;
   logic [7:0] received_sum_ff, received_sum_in;
   logic       sum_overflow_ff, sum_overflow_in;
   logic       length_exceeded_ff, length_exceeded_in;
   logic       fields_full_ff, fields_full_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       char_valid_ff, char_valid_in;
   logic [7:0] char_out_ff, char_out_in;
   logic [4:0] field_index_ff, field_index_in;
   logic [3:0] char_index_ff, char_index_in;
   logic       field_end_ff, field_end_in;
   logic       sentence_end_ff, sentence_end_in;
   logic       checksum_ok_ff, checksum_ok_in;
   logic       truncated_ff, truncated_in;

   logic                  accept;
   logic                  sum_overflow_mid;
   nscs_pkg::hex_digit_type digit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign digit     = nscs_pkg::hex_decode(req_data_byte);

   always_comb begin
      phase_in           = phase_ff;
      running_xor_in     = running_xor_ff;
      body_count_in      = body_count_ff;
      current_field_in   = current_field_ff;
      current_char_in    = current_char_ff;
      received_sum_in    = received_sum_ff;
      sum_overflow_in    = sum_overflow_ff;
      length_exceeded_in = length_exceeded_ff;
      fields_full_in     = fields_full_ff;
      sum_overflow_mid   = sum_overflow_ff;

      char_valid_in   = 1'b0;
      char_out_in     = 8'd0;
      field_index_in  = 5'd0;
      char_index_in   = 4'd0;
      field_end_in    = 1'b0;
      sentence_end_in = 1'b0;
      checksum_ok_in  = 1'b0;
      truncated_in    = 1'b0;

      if (phase_ff == PH_SUM) begin
         if (digit.valid) begin
            // Another digit on a value above 15 would not fit in a byte.
            sum_overflow_mid = sum_overflow_ff || (|received_sum_ff[7:4]);
            sum_overflow_in  = sum_overflow_mid;
            if (!sum_overflow_mid) begin
               received_sum_in = {received_sum_ff[3:0], digit.value};
            end
         end else begin
            sentence_end_in = 1'b1;
            checksum_ok_in  = !sum_overflow_ff && !length_exceeded_ff &&
                              (received_sum_ff == running_xor_ff);
            phase_in        = PH_IDLE;
         end
      end

      if (req_data_byte == nscs_pkg::CHAR_DOLLAR) begin
         phase_in           = PH_BODY;
         running_xor_in     = 8'd0;
         body_count_in      = 8'd0;
         current_field_in   = 5'd0;
         current_char_in    = 5'd0;
         received_sum_in    = 8'd0;
         sum_overflow_in    = 1'b0;
         length_exceeded_in = 1'b0;
         fields_full_in     = 1'b0;
      end else if (phase_ff == PH_BODY) begin
         if (req_data_byte == nscs_pkg::CHAR_STAR) begin
            if (!fields_full_ff) begin
               field_end_in   = 1'b1;
               field_index_in = current_field_ff;
            end
            received_sum_in = 8'd0;
            sum_overflow_in = 1'b0;
            phase_in        = PH_SUM;
         end else begin
            // Every other body byte, dropped or not, enters the checksum.
            running_xor_in = running_xor_ff ^ req_data_byte;
            if (body_count_ff >= BODY_MAX) begin
               length_exceeded_in = 1'b1;
            end else begin
               body_count_in = body_count_ff + 8'd1;
            end

            if (req_data_byte == nscs_pkg::CHAR_COMMA) begin
               if (fields_full_ff) begin
                  truncated_in = 1'b1;
               end else begin
                  field_end_in   = 1'b1;
                  field_index_in = current_field_ff;
                  if (current_field_ff >= LAST_FIELD) begin
                     fields_full_in = 1'b1;
                  end else begin
                     current_field_in = current_field_ff + 5'd1;
                  end
                  current_char_in = 5'd0;
               end
            end else if (fields_full_ff || current_char_ff >= CHAR_MAX) begin
               truncated_in = 1'b1;
            end else begin
               char_valid_in   = 1'b1;
               char_out_in     = req_data_byte;
               field_index_in  = current_field_ff;
               char_index_in   = current_char_ff[3:0];
               current_char_in = current_char_ff + 5'd1;
            end
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         running_xor_ff     <= 8'd0;
         body_count_ff      <= 8'd0;
         current_field_ff   <= 5'd0;
         current_char_ff    <= 5'd0;
         received_sum_ff    <= 8'd0;
         sum_overflow_ff    <= 1'b0;
         length_exceeded_ff <= 1'b0;
         fields_full_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff           <= phase_in;
            running_xor_ff     <= running_xor_in;
            body_count_ff      <= body_count_in;
            current_field_ff   <= current_field_in;
            current_char_ff    <= current_char_in;
            received_sum_ff    <= received_sum_in;
            sum_overflow_ff    <= sum_overflow_in;
            length_exceeded_ff <= length_exceeded_in;
            fields_full_ff     <= fields_full_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_valid_ff   <= char_valid_in;
         char_out_ff     <= char_out_in;
         field_index_ff  <= field_index_in;
         char_index_ff   <= char_index_in;
         field_end_ff    <= field_end_in;
         sentence_end_ff <= sentence_end_in;
         checksum_ok_ff  <= checksum_ok_in;
         truncated_ff    <= truncated_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_char_valid      = char_valid_ff;
   assign rsp_char_out        = char_out_ff;
   assign rsp_field_index     = field_index_ff;
   assign rsp_char_index      = char_index_ff;
   assign rsp_field_end       = field_end_ff;
   assign rsp_sentence_end    = sentence_end_ff;
   assign rsp_checksum_ok     = checksum_ok_ff;
   assign rsp_field_truncated = truncated_ff;

endmodule

// ===== rtl/core/nscs_checker.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker port assertions
// Watches the ports of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
`include "nmea_sentence_check_and_split_macros.svh"

module nscs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_char_valid,
   input logic       rsp_field_end,
   input logic       rsp_sentence_end,
   input logic       rsp_checksum_ok,
   input logic       rsp_field_truncated
);

   logic dollar_taken;
   logic char_shown;

   assign dollar_taken = req_valid && !req_stall && (req_data_byte == nscs_pkg::CHAR_DOLLAR);
   assign char_shown   = rsp_valid && rsp_char_valid;

   // Input is held back only by a result that is itself held back.
   `NSCS_ASSERT_NOW(stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Every accepted request produces a result in the following cycle.
   `NSCS_ASSERT_NEXT(request_gives_result, clock, reset, req_valid && !req_stall, rsp_valid)

   // A dollar is never itself a field character, field end or dropped byte.
   `NSCS_ASSERT_NEXT(dollar_is_not_body, clock, reset, dollar_taken,
      !rsp_char_valid && !rsp_field_end && !rsp_field_truncated)

   // A passing verdict only comes with the end of a sentence.
   `NSCS_ASSERT_NOW(verdict_needs_end, clock, reset, rsp_valid && rsp_checksum_ok,
      rsp_sentence_end)

   // A stored character excludes the end and drop markers.
   `NSCS_ASSERT_NOW(char_is_exclusive, clock, reset, char_shown,
      !rsp_field_end && !rsp_sentence_end && !rsp_field_truncated)

endmodule

bind nmea_sentence_check_and_split nscs_checker u_nscs_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Sentence checker and field splitter testbench
// Streams directed and random byte sequences through the splitter with
// random pauses and output stalls, predicts every result from a local model
// of the sentence state and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int BODY_LIMIT      = 128;
   localparam int MAX_FIELDS      = 32;
   localparam int MAX_FIELD_CHARS = 16;
   localparam int RANDOM_BYTES    = 1900;

   localparam logic [7:0] OPENING [25] = '{
      8'h00, 8'hFF, nscs_pkg::CHAR_DOLLAR, 8'h00, nscs_pkg::CHAR_COMMA, 8'hFF,
      nscs_pkg::CHAR_STAR, "d", "3",
      nscs_pkg::CHAR_DOLLAR, "J", nscs_pkg::CHAR_STAR, "4", "A", 8'h0D,
      nscs_pkg::CHAR_DOLLAR, nscs_pkg::CHAR_STAR, 8'h0D,
      nscs_pkg::CHAR_DOLLAR, "B", nscs_pkg::CHAR_STAR, "1", "4", "2", 8'h0A
   };

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_BODY, SCAN_SUM} scan_phase_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic [4:0] field_index;
      logic [3:0] char_index;
      logic       field_end;
      logic       sentence_end;
      logic       checksum_ok;
      logic       field_truncated;
   } split_result_type;

   typedef struct {
      logic [7:0]  data;
      int unsigned pause;
   } stream_byte_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_char_valid;
   logic [7:0] rsp_char_out;
   logic [4:0] rsp_field_index;
   logic [3:0] rsp_char_index;
   logic       rsp_field_end;
   logic       rsp_sentence_end;
   logic       rsp_checksum_ok;
   logic       rsp_field_truncated;

   // Local copy of the sentence state.
   scan_phase_type scan = SCAN_IDLE;
   logic [7:0]  sentence_xor = '0;
   logic [7:0]  body_len = '0;
   logic [4:0]  field_no = '0;
   logic [4:0]  char_no = '0;
   logic [7:0]  rx_sum = '0;
   logic        rx_overflow = 1'b0;
   logic        too_long = 1'b0;
   logic        fields_full = 1'b0;

   stream_byte_type  pending[$];
   split_result_type awaited_splits[$];

   int unsigned queued_total = 0;
   int unsigned bytes_taken = 0;
   int unsigned results_checked = 0;
   int unsigned error_count = 0;
   int unsigned sentences_passed = 0;
   int unsigned sentences_rejected = 0;
   int unsigned dropped_bytes = 0;
   int unsigned pause_left = 0;
   int unsigned stall_left = 0;
   logic        byte_taken = 1'b0;
   logic        rsp_taken = 1'b0;

   nmea_sentence_check_and_split #(
      .BODY_LIMIT      (BODY_LIMIT),
      .MAX_FIELDS      (MAX_FIELDS),
      .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_char_valid      (rsp_char_valid),
      .rsp_char_out        (rsp_char_out),
      .rsp_field_index     (rsp_field_index),
      .rsp_char_index      (rsp_char_index),
      .rsp_field_end       (rsp_field_end),
      .rsp_sentence_end    (rsp_sentence_end),
      .rsp_checksum_ok     (rsp_checksum_ok),
      .rsp_field_truncated (rsp_field_truncated)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Returns the digit value, or -1 when the byte is not a hex digit.
   function automatic int hex_weight(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return 8'("0") + 8'(n);
      return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
   endfunction

   function automatic void restart_sentence();
      sentence_xor = '0;
      body_len     = '0;
      field_no     = '0;
      char_no      = '0;
      rx_sum       = '0;
      rx_overflow  = 1'b0;
      too_long     = 1'b0;
      fields_full  = 1'b0;
   endfunction

   function automatic split_result_type split_byte(input logic [7:0] b);
      split_result_type r;
      int               digit;
      r     = '0;
      digit = hex_weight(b);
      if (scan == SCAN_SUM) begin
         if (digit >= 0) begin
            if (rx_sum > 8'd15) rx_overflow = 1'b1;
            if (!rx_overflow) rx_sum = {rx_sum[3:0], 4'(digit)};
         end else begin
            r.sentence_end = 1'b1;
            r.checksum_ok  = !rx_overflow && !too_long && rx_sum == sentence_xor;
            scan = SCAN_IDLE;
         end
      end
      if (b == nscs_pkg::CHAR_DOLLAR) begin
         restart_sentence();
         scan = SCAN_BODY;
      end else if (scan == SCAN_BODY) begin
         if (b == nscs_pkg::CHAR_STAR) begin
            if (!fields_full) begin
               r.field_end   = 1'b1;
               r.field_index = field_no;
            end
            rx_sum      = '0;
            rx_overflow = 1'b0;
            scan        = SCAN_SUM;
         end else begin
            // Every body byte counts towards the checksum, dropped or not.
            sentence_xor = sentence_xor ^ b;
            if (int'(body_len) >= BODY_LIMIT) too_long = 1'b1;
            else body_len = body_len + 8'd1;
            if (b == nscs_pkg::CHAR_COMMA) begin
               if (fields_full) begin
                  r.field_truncated = 1'b1;
               end else begin
                  r.field_end   = 1'b1;
                  r.field_index = field_no;
                  if (int'(field_no) + 1 >= MAX_FIELDS) fields_full = 1'b1;
                  else field_no = field_no + 5'd1;
                  char_no = '0;
               end
            end else if (fields_full || int'(char_no) >= MAX_FIELD_CHARS) begin
               r.field_truncated = 1'b1;
            end else begin
               r.char_valid  = 1'b1;
               r.char_out    = b;
               r.field_index = field_no;
               r.char_index  = char_no[3:0];
               char_no       = char_no + 5'd1;
            end
         end
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Requests flow with no pauses in one stretch of every four.
   task automatic push_byte(input logic [7:0] b);
      stream_byte_type it;
      it.data  = b;
      it.pause = ((queued_total / 250) % 4 == 1) ? 0 : $urandom_range(0, 15);
      pending.push_back(it);
      queued_total++;
   endtask

   // Any byte but the three delimiters; mostly printable text.
   function automatic logic [7:0] field_char();
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h20, 8'h7E))
                                          : 8'($urandom_range(0, 255));
      end while (c == nscs_pkg::CHAR_DOLLAR || c == nscs_pkg::CHAR_STAR ||
                 c == nscs_pkg::CHAR_COMMA);
      return c;
   endfunction

   // Result checking and request prediction, both on the rising edge.
   always @(posedge clock) begin
      split_result_type want;
      if (!reset) begin
         byte_taken <= req_valid && !req_stall;
         rsp_taken  <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (awaited_splits.size() == 0) begin
               $error("result arrived with no request outstanding");
               error_count++;
            end else begin
               want = awaited_splits.pop_front();
               compare_field("char_valid", want.char_valid, rsp_char_valid);
               compare_field("char_out", want.char_out, rsp_char_out);
               compare_field("field_index", want.field_index, rsp_field_index);
               compare_field("char_index", want.char_index, rsp_char_index);
               compare_field("field_end", want.field_end, rsp_field_end);
               compare_field("sentence_end", want.sentence_end, rsp_sentence_end);
               compare_field("checksum_ok", want.checksum_ok, rsp_checksum_ok);
               compare_field("field_truncated", want.field_truncated,
                             rsp_field_truncated);
               if (want.sentence_end && want.checksum_ok) sentences_passed++;
               if (want.sentence_end && !want.checksum_ok) sentences_rejected++;
               if (want.field_truncated) dropped_bytes++;
            end
         end
         if (req_valid && !req_stall) begin
            awaited_splits.push_back(split_byte(req_data_byte));
            bytes_taken++;
         end
      end
   end

   // Request driver: a request is held until taken, then the pause drawn for
   // it passes before the next one is offered.
   always @(negedge clock) begin
      stream_byte_type it;
      if (!reset && !(req_valid && !byte_taken)) begin
         if (pause_left > 0) begin
            req_valid  <= 1'b0;
            pause_left <= pause_left - 1;
         end else if (pending.size() > 0) begin
            it = pending.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= it.data;
            pause_left    <= it.pause;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stalls, drawn afresh after each result taken.
   always @(negedge clock) begin
      int unsigned hold;
      if (!reset) begin
         hold = stall_left;
         if (rsp_taken)
            hold = ((results_checked / 250) % 4 == 2) ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= hold - 1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
         end
      end
   end

   initial begin
      int unsigned kind;
      int unsigned nfields;
      int unsigned flen;
      int unsigned nbytes;
      int unsigned shape;
      logic [7:0]  xsum;
      logic [7:0]  sent_sum;
      logic [7:0]  c;

      foreach (OPENING[i]) push_byte(OPENING[i]);

      while (queued_total < RANDOM_BYTES + 25) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            // Well-formed sentence with random content.
            xsum = '0;
            push_byte(nscs_pkg::CHAR_DOLLAR);
            nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 40)
                                                  : $urandom_range(1, 8);
            for (int f = 0; f < nfields; f++) begin
               if (f > 0) begin
                  push_byte(nscs_pkg::CHAR_COMMA);
                  xsum = xsum ^ nscs_pkg::CHAR_COMMA;
               end
               flen = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20)
                                                  : $urandom_range(0, 6);
               for (int k = 0; k < flen; k++) begin
                  c = field_char();
                  push_byte(c);
                  xsum = xsum ^ c;
               end
            end
            push_byte(nscs_pkg::CHAR_STAR);
            sent_sum = ($urandom_range(0, 5) == 0) ? xsum ^ 8'($urandom_range(1, 255))
                                                   : xsum;
            shape = $urandom_range(0, 19);
            if (shape == 1) begin
               push_byte(hex_char(sent_sum[3:0], $urandom_range(0, 1)));
            end else if (shape != 0) begin
               // A third digit overflows unless the leading one is zero.
               if (shape == 2)
                  push_byte(hex_char($urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15)),
                                     $urandom_range(0, 1)));
               push_byte(hex_char(sent_sum[7:4], $urandom_range(0, 1)));
               push_byte(hex_char(sent_sum[3:0], $urandom_range(0, 1)));
            end
            if ($urandom_range(0, 3) == 0) begin
               push_byte(nscs_pkg::CHAR_DOLLAR);
            end else begin
               do c = 8'($urandom_range(0, 255)); while (hex_weight(c) >= 0);
               push_byte(c);
            end
         end else if (kind < 90) begin
            // Sentence cut short by a fresh dollar.
            push_byte(nscs_pkg::CHAR_DOLLAR);
            nbytes = $urandom_range(0, 12);
            for (int k = 0; k < nbytes; k++)
               push_byte(($urandom_range(0, 4) == 0) ? nscs_pkg::CHAR_COMMA : field_char());
         end else begin
            nbytes = $urandom_range(1, 8);
            for (int k = 0; k < nbytes; k++) begin
               case ($urandom_range(0, 5))
                  0: push_byte(nscs_pkg::CHAR_DOLLAR);
                  1: push_byte(nscs_pkg::CHAR_STAR);
                  2: push_byte(nscs_pkg::CHAR_COMMA);
                  default: push_byte(8'($urandom_range(0, 255)));
               endcase
            end
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_taken < queued_total || awaited_splits.size() > 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("%0d bytes checked: %0d sentences passed, %0d rejected, %0d bytes dropped",
               results_checked, sentences_passed, sentences_rejected, dropped_bytes);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
